[rtl/tpa_pkg.sv]
// Shared types and constants for the tachometer period averaging block.
// No dependencies; imported by tach_period_average_rpm (tpa_divider does not use it).
package tpa_pkg;

    // Request codes on the input channel
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic [31:0] RPM_NUM_RESET = 32'd1000000;
    localparam logic [31:0] U32_MAX       = 32'hFFFF_FFFF;

    typedef struct packed {
        logic req_type;
        logic pin_level;
    } in_t;

    typedef struct packed {
        logic [31:0] period_ticks;
        logic [31:0] average_ticks;
        logic [31:0] speed_rpm;
        logic        window_full;
    } out_t;

endpackage

[rtl/tpa_divider.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module tpa_divider #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quot_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[DVD_W-1]};
    assign fits    = (shifted >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[DVD_W-2:0], fits};
            if (fits)
                rem_reg <= DVS_W'(shifted - {1'b0, dvs_reg});
            else
                rem_reg <= shifted[DVS_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/tach_period_average_rpm.sv]
// Tachometer period averaging with speed in rpm; uses tpa_pkg and tpa_divider.
// Flow: a tick without a pin edge stays in S_IDLE; an edge after the first goes through
// S_UPDATE and S_DONE to the output register, or, with the window full, through S_UPDATE,
// S_MEAN (sliced reciprocal multiply), S_DIV_SPD (rpm divide unless mean is 0), S_DONE.
// Throughput: one item per cycle for plain ticks; edges hold off input until done.
// Reset: asynchronous, clears edge timing and window counters; the ring RAM is not cleared.
module tach_period_average_rpm
    import tpa_pkg::*;
#(
    parameter int WINDOW      = 40,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_t        out_data,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    // Ring address, fill count and running sum widths follow from the window depth.
    localparam int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = 32 + $clog2(WINDOW);
    localparam int EXT_W  = (COUNT_WIDTH + 1 > 33) ? COUNT_WIDTH + 1 : 33;
    localparam logic [COUNT_WIDTH-1:0] HALF_MAX = {COUNT_WIDTH{1'b1}};

    // Mean = floor(sum * M / 2^(SUM_W+LOG_W)) with M = ceil(2^(SUM_W+LOG_W) / WINDOW),
    // exact for every SUM_W-bit sum. M is consumed 16 bits per cycle, low slice first.
    localparam int LOG_W       = $clog2(WINDOW);
    localparam int SLICE       = 16;
    localparam int MUL_STEPS   = (SUM_W + SLICE) / SLICE;
    localparam int M_W         = MUL_STEPS * SLICE;
    localparam int ACC_W       = SUM_W + SLICE;
    localparam int STEP_W      = $clog2(MUL_STEPS + 1);
    localparam int RECIP_SHIFT = SUM_W + LOG_W - SLICE * (MUL_STEPS - 1);
    localparam logic [63:0] RECIP_M =
        ((64'd1 << (SUM_W + LOG_W)) + 64'(WINDOW - 1)) / 64'(WINDOW);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_UPDATE  = 5'b00010,
        S_MEAN    = 5'b00100,
        S_DIV_SPD = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_WIDTH-1:0]  tick_count_reg, tick_count_next;
    logic [COUNT_WIDTH-1:0]  last_half_reg, last_half_next;
    logic                    half_seen_reg, half_seen_next;
    logic                    prev_level_reg, prev_level_next;
    logic [AW-1:0]           ring_pos_reg, ring_pos_next;
    logic [FILL_W-1:0]       fill_count_reg, fill_count_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [31:0]             rpm_num_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    div_start_reg, div_start_next;

    // payload registers, no reset
    logic [31:0]             period_reg, period_next;
    logic [31:0]             avg_reg, avg_next;
    logic [31:0]             speed_reg, speed_next;
    logic                    full_reg, full_next;
    logic [31:0]             div_dvd_reg, div_dvd_next;
    logic [31:0]             div_dvs_reg, div_dvs_next;
    logic [SUM_W-1:0]        mul_x_reg, mul_x_next;
    logic [M_W-1:0]          mul_m_reg, mul_m_next;
    logic [ACC_W-1:0]        mul_acc_reg, mul_acc_next;
    logic [STEP_W-1:0]       mul_cnt_reg, mul_cnt_next;
    out_t                    out_data_reg, out_data_next;

    // Ring of stored periods: one write port, one registered read port.
    logic [31:0]             ring_mem [WINDOW];
    logic [31:0]             rd_data_reg;
    logic                    mem_we;

    logic [COUNT_WIDTH-1:0]  half_w;
    logic [EXT_W-1:0]        period_ext;
    logic [31:0]             period_sat;
    logic                    window_was_full;
    logic [FILL_W-1:0]       fill_inc;
    logic [SUM_W-1:0]        sum_upd;
    logic                    in_xfer;
    logic [ACC_W-1:0]        mul_acc_step;
    logic [31:0]             mean_w;

    logic                    div_busy;
    logic                    div_done;
    logic [31:0]             div_quot;

    tpa_divider #(
        .DVD_W (32),
        .DVS_W (32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dvd_reg),
        .divisor  (div_dvs_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Half-period ending at this tick, saturating; full period clamps to 32 bits.
    assign half_w     = (tick_count_reg == HALF_MAX) ? HALF_MAX
                                                     : tick_count_reg + COUNT_WIDTH'(1);
    assign period_ext = EXT_W'(last_half_reg) + EXT_W'(half_w);
    assign period_sat = (period_ext > EXT_W'(U32_MAX)) ? U32_MAX : period_ext[31:0];

    // Window update: drop the oldest period once the ring is full.
    assign window_was_full = (fill_count_reg == FILL_W'(WINDOW));
    assign fill_inc        = fill_count_reg + FILL_W'(1);
    assign sum_upd         = window_was_full
                           ? sum_reg - SUM_W'(rd_data_reg) + SUM_W'(period_reg)
                           : sum_reg + SUM_W'(period_reg);

    // One slice of the reciprocal product; low bits drop out as the slices advance.
    assign mul_acc_step = (mul_acc_reg >> SLICE)
                        + ACC_W'(mul_x_reg) * ACC_W'(mul_m_reg[SLICE-1:0]);
    assign mean_w       = 32'(mul_acc_step >> RECIP_SHIFT);

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        last_half_next  = last_half_reg;
        half_seen_next  = half_seen_reg;
        prev_level_next = prev_level_reg;
        ring_pos_next   = ring_pos_reg;
        fill_count_next = fill_count_reg;
        sum_next        = sum_reg;
        period_next     = period_reg;
        avg_next        = avg_reg;
        speed_next      = speed_reg;
        full_next       = full_reg;
        div_dvd_next    = div_dvd_reg;
        div_dvs_next    = div_dvs_reg;
        mul_x_next      = mul_x_reg;
        mul_m_next      = mul_m_reg;
        mul_acc_next    = mul_acc_reg;
        mul_cnt_next    = mul_cnt_reg;
        div_start_next  = 1'b0;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        mem_we          = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.req_type)
                        REQ_RESTART:
                        begin
                            ring_pos_next   = '0;
                            fill_count_next = '0;
                            sum_next        = '0;
                        end
                        REQ_TICK:
                        begin
                            if (in_data.pin_level == prev_level_reg)
                            begin
                                if (tick_count_reg != HALF_MAX)
                                    tick_count_next = tick_count_reg + COUNT_WIDTH'(1);
                            end
                            else
                            begin
                                prev_level_next = in_data.pin_level;
                                tick_count_next = '0;
                                last_half_next  = half_w;
                                half_seen_next  = 1'b1;
                                if (half_seen_reg)
                                begin
                                    // ring read of the oldest slot issued this edge
                                    period_next = period_sat;
                                    state_next  = S_UPDATE;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_UPDATE:
            begin
                mem_we        = 1'b1;
                sum_next      = sum_upd;
                ring_pos_next = (ring_pos_reg == AW'(WINDOW - 1)) ? '0
                                                                  : ring_pos_reg + AW'(1);
                if (!window_was_full)
                    fill_count_next = fill_inc;
                if (window_was_full || fill_inc == FILL_W'(WINDOW))
                begin
                    full_next    = 1'b1;
                    mul_x_next   = sum_upd;
                    mul_m_next   = M_W'(RECIP_M);
                    mul_acc_next = '0;
                    mul_cnt_next = STEP_W'(MUL_STEPS);
                    state_next   = S_MEAN;
                end
                else
                begin
                    full_next  = 1'b0;
                    avg_next   = '0;
                    speed_next = '0;
                    state_next = S_DONE;
                end
            end

            S_MEAN:
            begin
                mul_acc_next = mul_acc_step;
                mul_m_next   = mul_m_reg >> SLICE;
                mul_cnt_next = mul_cnt_reg - STEP_W'(1);
                if (mul_cnt_reg == STEP_W'(1))
                begin
                    avg_next = mean_w;
                    if (mean_w == '0)
                    begin
                        speed_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_dvd_next   = rpm_num_reg;
                        div_dvs_next   = mean_w;
                        div_start_next = 1'b1;
                        state_next     = S_DIV_SPD;
                    end
                end
            end

            S_DIV_SPD:
            begin
                if (div_done)
                begin
                    speed_next = div_quot;
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.period_ticks  = period_reg;
                    out_data_next.average_ticks = avg_reg;
                    out_data_next.speed_rpm     = speed_reg;
                    out_data_next.window_full   = full_reg;
                    state_next                  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_count_reg <= '0;
            last_half_reg  <= '0;
            half_seen_reg  <= 1'b0;
            prev_level_reg <= 1'b0;
            ring_pos_reg   <= '0;
            fill_count_reg <= '0;
            sum_reg        <= '0;
            rpm_num_reg    <= RPM_NUM_RESET;
            out_valid_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            last_half_reg  <= last_half_next;
            half_seen_reg  <= half_seen_next;
            prev_level_reg <= prev_level_next;
            ring_pos_reg   <= ring_pos_next;
            fill_count_reg <= fill_count_next;
            sum_reg        <= sum_next;
            out_valid_reg  <= out_valid_next;
            div_start_reg  <= div_start_next;
            if (cfg_we)
                rpm_num_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg   <= period_next;
        avg_reg      <= avg_next;
        speed_reg    <= speed_next;
        full_reg     <= full_next;
        div_dvd_reg  <= div_dvd_next;
        div_dvs_reg  <= div_dvs_next;
        mul_x_reg    <= mul_x_next;
        mul_m_reg    <= mul_m_next;
        mul_acc_reg  <= mul_acc_next;
        mul_cnt_reg  <= mul_cnt_next;
        out_data_reg <= out_data_next;
    end

    // Ring RAM: read of the current slot is always registered; the write happens in
    // the update cycle, after the old value has been captured.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[ring_pos_reg] <= period_reg;
        rd_data_reg <= ring_mem[ring_pos_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(WINDOW))
        else $error("fill count beyond window depth");

    a_update_follows_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE |-> $past(in_xfer))
        else $error("ring update without an input transfer");

    a_idle_divider: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_busy)
        else $error("input taken while divider is busy");

    a_speed_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV_SPD |-> div_dvs_reg != '0)
        else $error("speed division by zero mean");

    a_partial_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.window_full
            |-> out_data.average_ticks == '0 && out_data.speed_rpm == '0)
        else $error("mean or speed reported before window is full");
`endif

endmodule
